/* design/smx_pkg.sv */
// smx_pkg: shared constants, types and the exp approximation for the softmax row engine
// no dependencies
package smx_pkg;

  localparam int ROW_DEPTH_DEF = 64;
  localparam int SAMPLE_W      = 16;
  localparam int PROB_W        = 16;
  localparam int LEN_W         = 7;
  localparam int EXP_W         = 16;
  localparam int TOTAL_W       = 22;
  localparam int QUEUE_DEPTH   = 2;
  localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = 7'd64;
  localparam logic [16:0] LOG2E_Q15 = 17'd47274;
  localparam logic [1:0] ADDR_ROW_LENGTH = 2'd0;

  // a finished row handed from front to back
  typedef struct packed {
    logic [LEN_W-1:0]    count;
    logic [SAMPLE_W-1:0] row_max;
  } smx_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXP,
    BK_DIV,
    BK_EMIT
  } smx_back_state_t;

  function automatic logic [16:0] pow2_tab(input logic [4:0] idx);
    logic [16:0] v;
    begin
      unique case (idx)
        5'd0:    v = 17'd65536;
        5'd1:    v = 17'd62757;
        5'd2:    v = 17'd60097;
        5'd3:    v = 17'd57549;
        5'd4:    v = 17'd55109;
        5'd5:    v = 17'd52773;
        5'd6:    v = 17'd50535;
        5'd7:    v = 17'd48393;
        5'd8:    v = 17'd46341;
        5'd9:    v = 17'd44376;
        5'd10:   v = 17'd42495;
        5'd11:   v = 17'd40693;
        5'd12:   v = 17'd38968;
        5'd13:   v = 17'd37316;
        5'd14:   v = 17'd35734;
        5'd15:   v = 17'd34219;
        default: v = 17'd32768;
      endcase
      return v;
    end
  endfunction

  // p = d*log2(e) in q.16, d below 2^17
  function automatic logic [24:0] exp_scale(input logic [16:0] d);
    logic [33:0] prod;
    begin
      prod = 34'(d) * 34'(LOG2E_Q15) + 34'd256;
      return prod[33:9];
    end
  endfunction

  // exp(-d) in q1.15 from the scaled exponent
  function automatic logic [EXP_W:0] exp_from_p(input logic [24:0] p);
    logic [8:0]  n;
    logic [3:0]  i;
    logic [11:0] r;
    logic [16:0] ta;
    logic [16:0] tb;
    logic [29:0] corr;
    logic [16:0] v;
    logic [49:0] sum;
    begin
      n    = p[24:16];
      i    = p[15:12];
      r    = p[11:0];
      ta   = pow2_tab({1'b0, i});
      tb   = pow2_tab({1'b0, i} + 5'd1);
      corr = 30'(ta - tb) * 30'(r) + 30'd2048;
      v    = ta - 17'(corr[29:12]);
      if (n >= 9'd31) begin
        return '0;
      end
      sum = 50'(v) + (50'd1 << n);
      return 17'(sum >> (n + 9'd1));
    end
  endfunction

endpackage

/* design/smx_front.sv */
// smx_front: accepts samples, stores them and tracks the row maximum
// depends on smx_pkg
module smx_front #(
  parameter int ROW_DEPTH = smx_pkg::ROW_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [smx_pkg::SAMPLE_W-1:0] sample,
  input  logic [smx_pkg::LEN_W-1:0]    row_length,
  output logic                         wr_en,
  output logic [$clog2(ROW_DEPTH)-1:0] wr_addr,
  output logic [smx_pkg::SAMPLE_W-1:0] wr_data,
  output logic                         job_valid,
  output smx_pkg::smx_job_t            job
);
  import smx_pkg::*;

  localparam int AW = $clog2(ROW_DEPTH);

  logic [LEN_W-1:0]          fill_r;
  logic [LEN_W-1:0]          fill_nxt;
  logic signed [SAMPLE_W-1:0] max_r;
  logic signed [SAMPLE_W-1:0] max_nxt;
  logic [LEN_W-1:0]          count;
  logic [LEN_W-1:0]          eff_len;
  logic                      row_done;

  always_comb begin
    eff_len = row_length;
    if (row_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (row_length > LEN_W'(ROW_DEPTH)) begin
      eff_len = LEN_W'(ROW_DEPTH);
    end
    count    = fill_r + LEN_W'(1);
    row_done = (count >= eff_len);
    max_nxt  = ($signed(sample) > max_r) ? $signed(sample) : max_r;
    fill_nxt = row_done ? '0 : count;
  end

  assign wr_en     = accept;
  assign wr_addr   = fill_r[AW-1:0];
  assign wr_data   = sample;
  assign job_valid = accept && row_done;
  assign job.count   = count;
  assign job.row_max = max_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      max_r  <= 16'sh8000;
    end else if (accept) begin
      fill_r <= fill_nxt;
      max_r  <= row_done ? 16'sh8000 : max_nxt;
    end
  end

endmodule

/* design/smx_queue.sv */
// smx_queue: short job queue between front and back
// depends on smx_pkg
module smx_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  smx_pkg::smx_job_t push_job,
  input  logic              pop,
  output logic              not_empty,
  output logic              full,
  output smx_pkg::smx_job_t head
);
  import smx_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  smx_job_t        slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   rd_r;
  logic [PW-1:0]   rd_nxt;
  logic [PW-1:0]   wr_r;
  logic [PW-1:0]   wr_nxt;
  logic [PW:0]     cnt_r;
  logic [PW:0]     cnt_nxt;

  always_comb begin
    rd_nxt  = pop ? rd_r + PW'(1) : rd_r;
    wr_nxt  = push ? wr_r + PW'(1) : wr_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign head      = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_job;
    end
  end

endmodule

/* design/smx_div.sv */
// smx_div: restoring divider, one quotient bit per cycle, rounded and saturated
// depends on smx_pkg
module smx_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [smx_pkg::EXP_W:0]     num,
  input  logic [smx_pkg::TOTAL_W-1:0] den,
  output logic                        done,
  output logic [smx_pkg::PROB_W-1:0]  quot
);
  import smx_pkg::*;

  localparam int NW = EXP_W + 1 + 16 + 1;
  localparam int RW = TOTAL_W + 1;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]    num_r;
  logic [RW-1:0]    rem_r;
  logic [NW-1:0]    q_r;
  logic [TOTAL_W-1:0] den_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic [RW-1:0]    trial;
  logic [RW-1:0]    shifted;
  logic [NW-1:0]    dividend;

  // (e<<16) + total/2 feeds the shift register
  always_comb begin
    dividend = (NW'(num) << 16) + NW'(den >> 1);
    shifted  = {rem_r[RW-2:0], num_r[NW-1]};
    trial    = shifted - RW'(den_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      num_r <= dividend;
      rem_r <= '0;
      q_r   <= '0;
      den_r <= den;
    end else if (busy_r) begin
      num_r <= {num_r[NW-2:0], 1'b0};
      if (!trial[RW-1]) begin
        rem_r <= trial;
        q_r   <= {q_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= shifted;
        q_r   <= {q_r[NW-2:0], 1'b0};
      end
    end
  end

  assign quot = (q_r[NW-1:PROB_W] != '0) ? '1 : q_r[PROB_W-1:0];

endmodule

/* design/smx_back.sv */
// smx_back: exp pass with sum, then divide-and-emit pass over the stored row
// depends on smx_pkg, smx_div
module smx_back #(
  parameter int ROW_DEPTH = smx_pkg::ROW_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  input  smx_pkg::smx_job_t            job,
  output logic                         job_pop,
  input  logic                         wr_en,
  input  logic [$clog2(ROW_DEPTH)-1:0] wr_addr,
  input  logic [smx_pkg::SAMPLE_W-1:0] wr_data,
  output logic                         idle,
  output logic                         out_valid,
  output logic [smx_pkg::PROB_W-1:0]   out_probability,
  output logic                         out_row_end
);
  import smx_pkg::*;

  localparam int AW = $clog2(ROW_DEPTH);

  logic [SAMPLE_W-1:0] mem [ROW_DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic [AW-1:0]       rd_addr;

  smx_back_state_t state_r;
  smx_back_state_t state_nxt;

  logic [LEN_W-1:0]    idx_r;
  logic [LEN_W-1:0]    idx_nxt;
  logic [LEN_W-1:0]    count_r;
  logic signed [SAMPLE_W-1:0] max_r;
  logic [TOTAL_W-1:0]  total_r;
  logic [TOTAL_W-1:0]  total_nxt;
  logic [1:0]          ph_r;
  logic [1:0]          ph_nxt;
  logic [24:0]         p_r;
  logic [EXP_W:0]      e_val;
  logic [16:0]         diff;
  logic                div_go;
  logic                div_done;
  logic [PROB_W-1:0]   div_q;
  logic                last;

  assign rd_addr = idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // phase 0 address, 1 data -> scaled exponent, 2 exp ready
  always_comb begin
    diff  = 17'($signed({max_r[SAMPLE_W-1], max_r}) -
                $signed({rd_data_r[SAMPLE_W-1], rd_data_r}));
    e_val = exp_from_p(p_r);
    last  = (idx_r + LEN_W'(1) == count_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (job_valid) state_nxt = BK_EXP;
      BK_EXP:  if (ph_r == 2'd2 && last) state_nxt = BK_DIV;
      BK_DIV:  if (div_done) state_nxt = BK_EMIT;
      BK_EMIT: state_nxt = last ? BK_IDLE : BK_DIV;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    ph_nxt    = ph_r;
    idx_nxt   = idx_r;
    total_nxt = total_r;
    div_go    = 1'b0;
    job_pop   = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        ph_nxt    = '0;
        idx_nxt   = '0;
        total_nxt = '0;
        job_pop   = job_valid;
      end
      BK_EXP: begin
        ph_nxt = (ph_r == 2'd2) ? 2'd0 : ph_r + 2'd1;
        if (ph_r == 2'd2) begin
          total_nxt = total_r + TOTAL_W'(e_val);
          idx_nxt   = last ? '0 : idx_r + LEN_W'(1);
        end
      end
      BK_DIV: begin
        ph_nxt = (ph_r == 2'd3) ? ph_r : ph_r + 2'd1;
        div_go = (ph_r == 2'd2);
      end
      BK_EMIT: begin
        ph_nxt  = '0;
        idx_nxt = idx_r + LEN_W'(1);
      end
      default: ph_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ph_r    <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
    p_r     <= exp_scale(diff);
    if (state_r == BK_IDLE) begin
      count_r <= job.count;
      max_r   <= job.row_max;
    end
  end

  smx_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .num  (e_val),
    .den  (total_r),
    .done (div_done),
    .quot (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state_r == BK_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    out_probability <= div_q;
    out_row_end     <= last;
  end

  assign idle = (state_r == BK_IDLE);

endmodule

/* design/softmax_row_engine.sv */
// softmax_row_engine: top level, apb register, front, job queue and back
// depends on smx_pkg, smx_front, smx_queue, smx_back, smx_div
// Samples of a row are taken one a cycle while busy is low; each is written
// to the row memory. On the row's last sample the back end makes one pass
// computing exp(x - max) into the sum (paced by the registered memory read
// and exp stages) and a second pass dividing each element by the sum with a
// bit-serial divider (per element: fetch and form exp, one divider step per
// bit of the 34-bit dividend, done, then emit).
// Results leave on out_valid for one cycle each and cannot be stalled. busy is
// high while a row is being worked off, so the next row waits for it.
module softmax_row_engine #(
  parameter int ROW_DEPTH = smx_pkg::ROW_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [smx_pkg::SAMPLE_W-1:0] in_sample,
  output logic                         out_valid,
  output logic [smx_pkg::PROB_W-1:0]   out_probability,
  output logic                         out_row_end,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [1:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import smx_pkg::*;

  localparam int AW = $clog2(ROW_DEPTH);

  logic [LEN_W-1:0]    row_length_r;
  logic                accept;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [SAMPLE_W-1:0] wr_data;
  logic                fr_job_valid;
  smx_job_t            fr_job;
  logic                q_pop;
  logic                q_not_empty;
  logic                q_full;
  smx_job_t            q_head;
  logic                bk_idle;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ROW_LENGTH) ? 32'(row_length_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ROW_LENGTH_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_ROW_LENGTH) begin
      row_length_r <= pwdata[LEN_W-1:0];
    end
  end

  // back end reuses the row memory, so hold input while a row is pending
  assign busy   = q_full || q_not_empty || !bk_idle;
  assign accept = start && !busy;

  smx_front #(.ROW_DEPTH(ROW_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .sample    (in_sample),
    .row_length(row_length_r),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .job_valid (fr_job_valid),
    .job       (fr_job)
  );

  smx_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fr_job_valid),
    .push_job (fr_job),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .full     (q_full),
    .head     (q_head)
  );

  smx_back #(.ROW_DEPTH(ROW_DEPTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (q_not_empty),
    .job            (q_head),
    .job_pop        (q_pop),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .idle           (bk_idle),
    .out_valid      (out_valid),
    .out_probability(out_probability),
    .out_row_end    (out_row_end)
  );

endmodule

/* tb/softmax_row_engine_tb.sv */
// softmax_row_engine_tb: self-checking testbench for the softmax row engine
// drives rows of q5.10 samples and checks each probability beat against a
// fixed-point softmax predictor; depends on smx_pkg and softmax_row_engine
module softmax_row_engine_tb;
  import smx_pkg::*;

  localparam int DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  class prob_scoreboard;
    logic [15:0] row_buf [DEPTH];
    int row_fill;
    int row_peak;
    int row_len;
    logic [15:0] want_prob [$];
    bit want_end [$];
    int errors;
    int checked;

    function new();
      row_fill = 0;
      row_peak = -32768;
      row_len = 64;
      errors = 0;
      checked = 0;
    endfunction

    function automatic int pow2_entry(int idx);
      int t [17];
      t = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
            44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
      return t[idx];
    endfunction

    function automatic longint exp_neg(longint d);
      longint p, n, f, i, r, v;
      p = (d * 47274 + 256) >>> 9;
      n = p >>> 16;
      f = p & 16'hffff;
      i = f >>> 12;
      r = f & 12'hfff;
      v = pow2_entry(i) - (((pow2_entry(i) - pow2_entry(i + 1)) * r + 2048) >>> 12);
      if (n + 1 >= 32) return 0;
      return (v + (longint'(1) << n)) >>> (n + 1);
    endfunction

    function void set_length(logic [6:0] v);
      row_len = v;
    endfunction

    function void note_sample(logic [15:0] s);
      int lim, cnt;
      longint e [DEPTH];
      longint total, q;
      row_buf[row_fill] = s;
      if ($signed(s) > row_peak) row_peak = $signed(s);
      cnt = row_fill + 1;
      lim = (row_len == 0) ? 1 : (row_len > DEPTH ? DEPTH : row_len);
      if (cnt < lim && cnt < DEPTH) begin
        row_fill = cnt;
        return;
      end
      total = 0;
      for (int k = 0; k < cnt; k++) begin
        e[k] = exp_neg(longint'(row_peak - int'($signed(row_buf[k]))));
        total = (total + e[k]) & 22'h3fffff;
      end
      for (int k = 0; k < cnt; k++) begin
        q = 65535;
        if (total != 0) begin
          q = ((e[k] << 16) + (total >>> 1)) / total;
          if (q > 65535) q = 65535;
        end
        want_prob.push_back(q[15:0]);
        want_end.push_back(k + 1 == cnt);
      end
      row_fill = 0;
      row_peak = -32768;
    endfunction

    function void check_beat(logic [15:0] prob, logic last);
      logic [15:0] ep;
      bit ee;
      checked++;
      if (want_prob.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat prob=%0d row_end=%0b", $time, prob, last);
        return;
      end
      ep = want_prob.pop_front();
      ee = want_end.pop_front();
      if (prob !== ep) begin
        errors++;
        $display("%0t: probability expected %0d actual %0d", $time, ep, prob);
      end
      if (last !== ee) begin
        errors++;
        $display("%0t: row_end expected %0b actual %0b", $time, ee, last);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [15:0] in_sample = '0;
  logic out_valid;
  logic [15:0] out_probability;
  logic out_row_end;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  prob_scoreboard sb = new();
  int idle_cycles = 0;
  int samples_sent = 0;
  int rows_done = 0;
  bit quiet_phase = 0;

  softmax_row_engine dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_sample(in_sample),
    .out_valid(out_valid), .out_probability(out_probability),
    .out_row_end(out_row_end), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_beat(out_probability, out_row_end);
      if (out_row_end) rows_done++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_length(logic [6:0] v);
    start <= 0;
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_ROW_LENGTH; pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_length(v);
  endtask

  task automatic send_sample(logic [15:0] s);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    start <= 1;
    in_sample <= s;
    do @(posedge clk); while (busy);
    sb.note_sample(s);
    samples_sent++;
  endtask

  task automatic drain;
    start <= 0;
    while (sb.want_prob.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 8191)) - 16'd4096;
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom_range(0, 1023));
    endcase
  endfunction

  initial begin
    int len;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // single-element rows at lengths 1 and 0, then rows of 4 and a length above the depth
    write_length(7'd1);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    drain();
    write_length(7'd0);
    send_sample(16'h0000);
    drain();
    write_length(7'd4);
    send_sample(16'h8000); send_sample(16'h7fff);
    send_sample(16'h8000); send_sample(16'h7fff);
    send_sample(16'h1234); send_sample(16'h1234);
    send_sample(16'h1234); send_sample(16'h1234);
    drain();
    write_length(7'd127);
    for (int k = 0; k < 64; k++) send_sample(16'($urandom));
    drain();
    // mid-row length change
    write_length(7'd5);
    send_sample(16'h0400); send_sample(16'hfc00); send_sample(16'h0000);
    drain();
    write_length(7'd2);
    send_sample(16'h0100);
    drain();
    while (samples_sent < 300) begin
      if (samples_sent > 260) quiet_phase = 1;
      case ($urandom_range(0, 5))
        0: len = 1;
        1: len = 64;
        default: len = $urandom_range(2, 12);
      endcase
      write_length(7'(len));
      for (int k = 0; k < len; k++) send_sample(rand_sample());
      drain();
    end
    write_length(7'd64);
    drain();
    $display("covered %0d samples in %0d rows, %0d probability beats checked",
             samples_sent, rows_done, sb.checked);
    if (sb.errors == 0 && sb.want_prob.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* sim.f */
design/smx_pkg.sv
design/smx_front.sv
design/smx_queue.sv
design/smx_div.sv
design/smx_back.sv
design/softmax_row_engine.sv
tb/softmax_row_engine_tb.sv
